// ===== rtl/bpb_pkg.sv =====
// shared types, codes and reset values for the battery protect and balance controller
// no dependencies; used by every module of the block
package bpb_pkg;

    localparam int MAX_SLOTS     = 9;
    localparam int NUM_CELLS_DEF = 9;
    localparam int SLOT_W        = $clog2(MAX_SLOTS);
    localparam int MV_W          = 13;
    localparam int CUR_W         = 16;
    localparam int TEMP_W        = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // item modes
    localparam logic [1:0] MODE_SAMPLE_ON  = 2'd0;
    localparam logic [1:0] MODE_SAMPLE_OFF = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT    = 2'd2;
    localparam logic [1:0] MODE_BALANCE    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OV_SET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OV_CLEAR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UV_SET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UV_CLEAR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OC_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OT_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UT_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BAL_GAP  = 3'd7;

    // mosfet commands
    localparam logic [2:0] MOS_NONE       = 3'd0;
    localparam logic [2:0] MOS_CLOSE_BOTH = 3'd1;
    localparam logic [2:0] MOS_CLOSE_CHG  = 3'd2;
    localparam logic [2:0] MOS_CLOSE_DSG  = 3'd3;
    localparam logic [2:0] MOS_OPEN_BOTH  = 3'd4;

    // balance commands
    localparam logic [1:0] BAL_NONE  = 2'd0;
    localparam logic [1:0] BAL_STOP  = 2'd1;
    localparam logic [1:0] BAL_START = 2'd2;

    typedef logic [MV_W-1:0] mv_t;

    typedef struct packed {
        mv_t                      ov_set;
        mv_t                      ov_clear;
        mv_t                      uv_set;
        mv_t                      uv_clear;
        logic signed [CUR_W-1:0]  oc_limit;
        logic signed [TEMP_W-1:0] ot_limit;
        logic signed [TEMP_W-1:0] ut_limit;
        mv_t                      bal_gap;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        ov_set:   13'd4200,
        ov_clear: 13'd4100,
        uv_set:   13'd2800,
        uv_clear: 13'd3000,
        oc_limit: 16'sd2000,
        ot_limit: 12'sd600,
        ut_limit: 12'sd0,
        bal_gap:  13'd50
    };

    typedef struct packed {
        logic [1:0]               mode;
        mv_t [MAX_SLOTS-1:0]      cell_mv;
        logic signed [CUR_W-1:0]  cur;
        logic signed [TEMP_W-1:0] temp;
    } item_t;

    typedef struct packed {
        logic ov;
        logic uv;
        logic oc;
        logic ot;
        logic ut;
    } flags_t;

    typedef struct packed {
        logic [2:0] mos;
        logic       clr;
        logic [1:0] bal;
        logic [3:0] bcell;
        flags_t     flags;
    } res_t;

    // monitor slot to physical cell number
    function automatic logic [3:0] phys_cell(input logic [SLOT_W-1:0] slot);
        logic [3:0] num;
        case (slot)
            4'd0:    num = 4'd0;
            4'd1:    num = 4'd1;
            4'd2:    num = 4'd4;
            4'd3:    num = 4'd5;
            4'd4:    num = 4'd6;
            4'd5:    num = 4'd9;
            4'd6:    num = 4'd10;
            4'd7:    num = 4'd11;
            4'd8:    num = 4'd14;
            default: num = 4'd0;
        endcase
        return num;
    endfunction

endpackage

// ===== rtl/battery_protect_balance_controller_unit.sv =====
// battery protect and balance controller: input register, one evaluation pass, result register
// an accepted input beat passes through the input register, then the result register, to the output
// throughput: one item per cycle; input stays ready while the result register can drain
// fault flags update as an item moves into the result register, so the next item sees them
// reset: flags clear, thresholds take their defaults, both stages empty
// depends on bpb_pkg and bpb_eval
module battery_protect_balance_controller_unit #(
    parameter int NUM_CELLS = bpb_pkg::NUM_CELLS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bpb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [bpb_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             mode,
    input  logic [bpb_pkg::MV_W-1:0]               cell_mv_0,
    input  logic [bpb_pkg::MV_W-1:0]               cell_mv_1,
    input  logic [bpb_pkg::MV_W-1:0]               cell_mv_2,
    input  logic [bpb_pkg::MV_W-1:0]               cell_mv_3,
    input  logic [bpb_pkg::MV_W-1:0]               cell_mv_4,
    input  logic [bpb_pkg::MV_W-1:0]               cell_mv_5,
    input  logic [bpb_pkg::MV_W-1:0]               cell_mv_6,
    input  logic [bpb_pkg::MV_W-1:0]               cell_mv_7,
    input  logic [bpb_pkg::MV_W-1:0]               cell_mv_8,
    input  logic signed [bpb_pkg::CUR_W-1:0]       pack_current_ma,
    input  logic signed [bpb_pkg::TEMP_W-1:0]      temp_dc,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [2:0]                             mos_action,
    output logic                                   clear_status,
    output logic [1:0]                             balance_action,
    output logic [3:0]                             balance_cell,
    output logic                                   ov_flag,
    output logic                                   uv_flag,
    output logic                                   oc_flag,
    output logic                                   ot_flag,
    output logic                                   ut_flag
);

    bpb_pkg::cfg_t   cfg_reg;
    bpb_pkg::item_t  item_reg;
    bpb_pkg::item_t  item_next;
    logic            item_valid_reg;
    bpb_pkg::flags_t flags_reg;
    bpb_pkg::flags_t flags_next;
    bpb_pkg::res_t   res_reg;
    bpb_pkg::res_t   res_next;
    logic            out_valid_reg;
    logic            out_free;
    logic            advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= bpb_pkg::CFG_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bpb_pkg::REG_OV_SET:   cfg_reg.ov_set   <= cfg_data[bpb_pkg::MV_W-1:0];
                bpb_pkg::REG_OV_CLEAR: cfg_reg.ov_clear <= cfg_data[bpb_pkg::MV_W-1:0];
                bpb_pkg::REG_UV_SET:   cfg_reg.uv_set   <= cfg_data[bpb_pkg::MV_W-1:0];
                bpb_pkg::REG_UV_CLEAR: cfg_reg.uv_clear <= cfg_data[bpb_pkg::MV_W-1:0];
                bpb_pkg::REG_OC_LIMIT: cfg_reg.oc_limit <= cfg_data[bpb_pkg::CUR_W-1:0];
                bpb_pkg::REG_OT_LIMIT: cfg_reg.ot_limit <= cfg_data[bpb_pkg::TEMP_W-1:0];
                bpb_pkg::REG_UT_LIMIT: cfg_reg.ut_limit <= cfg_data[bpb_pkg::TEMP_W-1:0];
                bpb_pkg::REG_BAL_GAP:  cfg_reg.bal_gap  <= cfg_data[bpb_pkg::MV_W-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = item_valid_reg && out_free;
    assign in_ready = !item_valid_reg || out_free;

    always_comb
    begin
        item_next.mode       = mode;
        item_next.cell_mv[0] = cell_mv_0;
        item_next.cell_mv[1] = cell_mv_1;
        item_next.cell_mv[2] = cell_mv_2;
        item_next.cell_mv[3] = cell_mv_3;
        item_next.cell_mv[4] = cell_mv_4;
        item_next.cell_mv[5] = cell_mv_5;
        item_next.cell_mv[6] = cell_mv_6;
        item_next.cell_mv[7] = cell_mv_7;
        item_next.cell_mv[8] = cell_mv_8;
        item_next.cur        = pack_current_ma;
        item_next.temp       = temp_dc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

    bpb_eval #(
        .NUM_CELLS (NUM_CELLS)
    ) u_eval (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .res        (res_next)
    );

    // result stage and fault state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= item_valid_reg;
            if (advance)
                flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid      = out_valid_reg;
    assign mos_action     = res_reg.mos;
    assign clear_status   = res_reg.clr;
    assign balance_action = res_reg.bal;
    assign balance_cell   = res_reg.bcell;
    assign ov_flag        = res_reg.flags.ov;
    assign uv_flag        = res_reg.flags.uv;
    assign oc_flag        = res_reg.flags.oc;
    assign ot_flag        = res_reg.flags.ot;
    assign ut_flag        = res_reg.flags.ut;

endmodule

// ===== rtl/bpb_eval.sv =====
// one-pass evaluation of a snapshot: fault flag update, mosfet and balance decision
// depends on bpb_pkg
module bpb_eval #(
    parameter int NUM_CELLS = bpb_pkg::NUM_CELLS_DEF
) (
    input  bpb_pkg::item_t  item,
    input  bpb_pkg::cfg_t   cfg,
    input  bpb_pkg::flags_t flags,
    output bpb_pkg::flags_t flags_next,
    output bpb_pkg::res_t   res
);

    localparam int SLOTS_USED = (NUM_CELLS > bpb_pkg::MAX_SLOTS) ? bpb_pkg::MAX_SLOTS
                                                                 : NUM_CELLS;

    logic                       ov_hit, ov_ok, uv_hit, uv_ok;
    logic                       oc_hit, ot_hit, ut_hit;
    logic                       is_sample;
    logic                       changed, any_now, any_old;
    bpb_pkg::flags_t            upd;
    bpb_pkg::flags_t            chg;
    bpb_pkg::mv_t               mx, mn, spread;
    logic [bpb_pkg::SLOT_W-1:0] mi;

    // raise when clear, else drop when set and the clear condition holds
    function automatic logic [1:0] step_flag(input logic f, input logic raise,
                                             input logic clr);
        logic [1:0] r;
        if (raise && !f)
            r = 2'b11;
        else if (f && clr)
            r = 2'b10;
        else
            r = {1'b0, f};
        return r;
    endfunction

    always_comb
    begin
        ov_hit = 1'b0;
        ov_ok  = 1'b1;
        uv_hit = 1'b0;
        uv_ok  = 1'b1;
        for (int i = 0; i < SLOTS_USED; i++)
        begin
            if (item.cell_mv[i] > cfg.ov_set)
                ov_hit = 1'b1;
            if (item.cell_mv[i] >= cfg.ov_clear)
                ov_ok = 1'b0;
            if (item.cell_mv[i] < cfg.uv_set)
                uv_hit = 1'b1;
            if (item.cell_mv[i] <= cfg.uv_clear)
                uv_ok = 1'b0;
        end
    end

    assign oc_hit = $signed(item.cur) > $signed(cfg.oc_limit);
    assign ot_hit = $signed(item.temp) > $signed(cfg.ot_limit);
    assign ut_hit = $signed(item.temp) < $signed(cfg.ut_limit);

    assign {chg.ov, upd.ov} = step_flag(flags.ov, ov_hit, ov_ok);
    assign {chg.uv, upd.uv} = step_flag(flags.uv, uv_hit, uv_ok);
    assign {chg.oc, upd.oc} = step_flag(flags.oc, oc_hit, !oc_hit);
    assign {chg.ot, upd.ot} = step_flag(flags.ot, ot_hit, !ot_hit);
    assign {chg.ut, upd.ut} = step_flag(flags.ut, ut_hit, !ut_hit);

    assign is_sample = (item.mode == bpb_pkg::MODE_SAMPLE_ON) ||
                       (item.mode == bpb_pkg::MODE_SAMPLE_OFF);
    assign changed   = |chg;
    assign any_now   = |upd;
    assign any_old   = |flags;

    assign flags_next = is_sample ? upd : flags;

    // spread and first slot holding the maximum
    always_comb
    begin
        mx = item.cell_mv[0];
        mn = item.cell_mv[0];
        mi = '0;
        for (int i = 1; i < SLOTS_USED; i++)
        begin
            if (item.cell_mv[i] < mn)
                mn = item.cell_mv[i];
            if (item.cell_mv[i] > mx)
            begin
                mx = item.cell_mv[i];
                mi = bpb_pkg::SLOT_W'(i);
            end
        end
    end

    assign spread = mx - mn;

    always_comb
    begin
        res       = '0;
        res.flags = flags_next;
        case (item.mode)
            bpb_pkg::MODE_SAMPLE_ON,
            bpb_pkg::MODE_SAMPLE_OFF:
            begin
                res.clr = 1'b1;
                if (changed)
                begin
                    if (upd.oc || upd.ot || upd.ut)
                        res.mos = bpb_pkg::MOS_CLOSE_BOTH;
                    else if (upd.ov && upd.uv)
                        res.mos = bpb_pkg::MOS_CLOSE_BOTH;
                    else if (upd.ov)
                        res.mos = bpb_pkg::MOS_CLOSE_CHG;
                    else if (upd.uv)
                        res.mos = bpb_pkg::MOS_CLOSE_DSG;
                    else
                        res.mos = bpb_pkg::MOS_OPEN_BOTH;
                end
                else if (!any_now && item.mode == bpb_pkg::MODE_SAMPLE_OFF)
                begin
                    res.mos = bpb_pkg::MOS_OPEN_BOTH;
                end
            end
            bpb_pkg::MODE_TIMEOUT:
            begin
                res.mos = bpb_pkg::MOS_CLOSE_BOTH;
                res.clr = 1'b1;
            end
            default:
            begin
                if (any_old)
                    res.bal = bpb_pkg::BAL_STOP;
                else if (spread > cfg.bal_gap)
                begin
                    res.bal   = bpb_pkg::BAL_START;
                    res.bcell = bpb_pkg::phys_cell(mi);
                end
                else
                    res.bal = bpb_pkg::BAL_STOP;
            end
        endcase
    end

endmodule

// ===== rtl/bpb_check.sv =====
// port-level checks for the battery protect and balance controller, bound to the top level
// depends on bpb_pkg and battery_protect_balance_controller_unit
module bpb_check (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] mos_action,
    input logic       clear_status,
    input logic [1:0] balance_action,
    input logic [3:0] balance_cell,
    input logic       ov_flag,
    input logic       uv_flag,
    input logic       oc_flag,
    input logic       ot_flag,
    input logic       ut_flag
);

    // a stalled result beat holds its mosfet and balance fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mos_action) &&
        $stable(balance_action) && $stable(balance_cell))
    else $error("result beat changed while stalled");

    // balance beats never carry a mosfet command or a status clear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && balance_action != bpb_pkg::BAL_NONE |->
        mos_action == bpb_pkg::MOS_NONE && !clear_status)
    else $error("balance beat with mosfet command");

    // a beat without status clear is a balance check, which always decides something
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !clear_status |-> balance_action != bpb_pkg::BAL_NONE)
    else $error("balance check without decision");

    // bleeding only starts with no fault latched
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && balance_action == bpb_pkg::BAL_START |->
        !(ov_flag || uv_flag || oc_flag || ot_flag || ut_flag))
    else $error("balancing started under a fault");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && balance_action != bpb_pkg::BAL_START |-> balance_cell == 4'd0)
    else $error("cell number without balance start");

endmodule

bind battery_protect_balance_controller_unit bpb_check u_bpb_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mos_action     (mos_action),
    .clear_status   (clear_status),
    .balance_action (balance_action),
    .balance_cell   (balance_cell),
    .ov_flag        (ov_flag),
    .uv_flag        (uv_flag),
    .oc_flag        (oc_flag),
    .ot_flag        (ot_flag),
    .ut_flag        (ut_flag)
);
